/* rtl/ps2md_pkg.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Shared constants, event codes and the packet descriptor that travels from
// the packet assembler to the event sequencer.
// ---------------------------------------------------------------------------
package ps2md_pkg;

    // Status bit that marks a byte from the auxiliary (mouse) port.
    localparam int AUX_BIT      = 5;
    // Number of button bits carried in byte 0 of a packet.
    localparam int BUTTON_BITS  = 3;
    // Packet position of the byte that completes a packet.
    localparam logic [1:0] LAST_POS = 2'd2;

    // Event codes as seen on the result channel.
    typedef enum logic [1:0] {
        EV_MOVE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_kind_t;

    // One completed packet, already reduced to the events it causes.
    typedef struct packed {
        logic                   move_valid;
        logic [7:0]             delta_x;
        logic [7:0]             delta_y;
        logic [BUTTON_BITS-1:0] change;
        logic [BUTTON_BITS-1:0] was_down;
    } pkt_desc_t;

endpackage

/* rtl/ps2md_front.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse packet assembler
// Accepts status/data byte pairs, drops non-auxiliary bytes, gathers three
// byte packets and turns each completed packet into an event descriptor.
// ---------------------------------------------------------------------------
module ps2md_front #(
    parameter int BUTTON_COUNT = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic [7:0]           in_status,
    input  logic [7:0]           in_data,
    output logic                 push,
    output ps2md_pkg::pkt_desc_t push_desc
);
    import ps2md_pkg::*;

    logic [1:0]             pos_reg, pos_next;
    logic [7:0]             held0_reg, held1_reg;
    logic [BUTTON_BITS-1:0] btn_reg, btn_next;
    logic                   aux;
    logic                   complete;
    logic [BUTTON_BITS-1:0] change;

    assign aux      = in_valid && in_status[AUX_BIT];
    // A stuck position of three is treated like two: the byte completes the packet.
    assign complete = aux && (pos_reg >= LAST_POS);
    assign push     = complete;

    // Button changes, limited to the buttons that are reported.
    always_comb begin
        for (int i = 0; i < BUTTON_BITS; i++) begin
            change[i] = (i < BUTTON_COUNT) && (held0_reg[i] != btn_reg[i]);
        end
    end

    // Descriptor of the packet that the current byte completes.
    always_comb begin
        push_desc.move_valid = (held1_reg != 8'd0) || (in_data != 8'd0);
        push_desc.delta_x    = held1_reg;
        push_desc.delta_y    = 8'd0 - in_data;
        push_desc.change     = change;
        push_desc.was_down   = btn_reg;
    end

    // Next packet position and stored button bits.
    always_comb begin
        pos_next = pos_reg;
        btn_next = btn_reg;
        if (complete) begin
            pos_next = 2'd0;
            btn_next = held0_reg[BUTTON_BITS-1:0];
        end else if (aux) begin
            pos_next = pos_reg + 2'd1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 2'd0;
            btn_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            btn_reg <= btn_next;
        end
    end

    // Held packet bytes; written before they are ever read.
    always_ff @(posedge aclk) begin
        if (aux && !complete) begin
            if (pos_reg[0]) begin
                held1_reg <= in_data;
            end else begin
                held0_reg <= in_data;
            end
        end
    end

endmodule

/* rtl/ps2md_queue.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse descriptor queue
// Two-entry queue of packet descriptors between the assembler and the
// event sequencer.
// ---------------------------------------------------------------------------
module ps2md_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ps2md_pkg::pkt_desc_t push_desc,
    input  logic                 pop,
    output ps2md_pkg::pkt_desc_t pop_desc,
    output logic                 full,
    output logic                 empty
);
    import ps2md_pkg::*;

    pkt_desc_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_desc = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Descriptor storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* rtl/ps2md_back.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse event sequencer
// Takes one packet descriptor at a time and issues its events, move first
// and then buttons 1 to 3, one per cycle while the output register is free.
// ---------------------------------------------------------------------------
module ps2md_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  ps2md_pkg::pkt_desc_t q_desc,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);
    import ps2md_pkg::*;

    // Working descriptor.
    logic                   move_reg, move_next;
    logic [BUTTON_BITS-1:0] change_reg, change_next;
    logic [BUTTON_BITS-1:0] down_reg;
    logic [7:0]             dx_reg, dy_reg;

    // Output register.
    logic                   ovalid_reg, ovalid_next;
    event_kind_t            okind_reg;
    logic [7:0]             odx_reg, ody_reg;
    logic [1:0]             obtn_reg;
    logic                   olast_reg;

    logic                   busy;
    logic                   out_free;
    logic                   emit;
    logic [1:0]             sel_idx;
    event_kind_t            sel_kind;
    logic [7:0]             sel_dx, sel_dy;
    logic [1:0]             sel_btn;
    logic                   sel_last;

    assign busy     = move_reg || (change_reg != '0);
    assign out_free = !ovalid_reg || m_tready;
    assign emit     = busy && out_free;
    assign q_pop    = !busy && !q_empty;

    // Pick the next event of the working packet.
    always_comb begin
        sel_idx = 2'd0;
        for (int i = BUTTON_BITS - 1; i >= 0; i--) begin
            if (change_reg[i]) begin
                sel_idx = 2'(i);
            end
        end
        move_next   = move_reg;
        change_next = change_reg;
        if (move_reg) begin
            sel_kind  = EV_MOVE;
            sel_dx    = dx_reg;
            sel_dy    = dy_reg;
            sel_btn   = 2'd0;
            sel_last  = (change_reg == '0);
            move_next = 1'b0;
        end else begin
            sel_kind    = down_reg[sel_idx] ? EV_RELEASE : EV_PRESS;
            sel_dx      = 8'd0;
            sel_dy      = 8'd0;
            sel_btn     = sel_idx + 2'd1;
            change_next = change_reg & ~(BUTTON_BITS'(1) << sel_idx);
            sel_last    = (change_next == '0);
        end
    end

    // Output valid flag.
    always_comb begin
        ovalid_next = ovalid_reg;
        if (emit) begin
            ovalid_next = 1'b1;
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end
    end

    // Control state of the sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_reg   <= 1'b0;
            change_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
            if (q_pop) begin
                move_reg   <= q_desc.move_valid;
                change_reg <= q_desc.change;
            end else if (emit) begin
                move_reg   <= move_next;
                change_reg <= change_next;
            end
        end
    end

    // Payload of the working packet.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            dx_reg   <= q_desc.delta_x;
            dy_reg   <= q_desc.delta_y;
            down_reg <= q_desc.was_down;
        end
    end

    // Payload of the output register.
    always_ff @(posedge aclk) begin
        if (emit) begin
            okind_reg <= sel_kind;
            odx_reg   <= sel_dx;
            ody_reg   <= sel_dy;
            obtn_reg  <= sel_btn;
            olast_reg <= sel_last;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {6'd0, obtn_reg, ody_reg, odx_reg};
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

endmodule

/* rtl/ps2_mouse_packet_decoder.sv */
// ---------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Gathers three-byte mouse packets from controller status/data byte pairs
// and reports movement and button press/release events.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel carries one status byte and one data byte per transfer.
//   Transfers whose status bit 5 is clear are consumed and dropped. Every
//   third auxiliary byte completes a packet, which yields up to four events:
//   a move event when either delta is nonzero, then one press or release
//   event per changed button in the order 1, 2, 3. m_tlast marks the last
//   event of a packet; a packet with nothing to report yields no transfer.
//   A completed packet passes through the queue and the working descriptor
//   before its first event enters the output register. While the receiver
//   is ready the sequencer issues one event per cycle; it loads a packet only
//   when the last is drained. Input bytes are taken every cycle while the
//   two-entry packet queue has room. When the receiver stalls, the output
//   register holds its event and the queue fills; s_tready then drops until
//   room frees up. Reset clears the packet position, the stored button bits,
//   the queue and the output register; no clearing pass is needed.
// ---------------------------------------------------------------------------
module ps2_mouse_packet_decoder #(
    parameter int BUTTON_COUNT = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] status_byte, [15:8] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] delta_x, [15:8] delta_y, [17:16] button_number
    output logic [1:0]  m_tuser,   // [1:0] event_kind
    output logic        m_tlast    // last_of_run
);
    import ps2md_pkg::*;

    logic      q_push, q_pop, q_full, q_empty;
    pkt_desc_t push_desc, pop_desc;
    logic      in_xfer;

    // Input is held off only while the packet queue is full.
    assign s_tready = !q_full;
    assign in_xfer  = s_tvalid && s_tready;

    ps2md_front #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_xfer),
        .in_status (s_tdata[7:0]),
        .in_data   (s_tdata[15:8]),
        .push      (q_push),
        .push_desc (push_desc)
    );

    ps2md_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .pop_desc  (pop_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    ps2md_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_desc   (pop_desc),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
